// File: rtl/krt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table: field widths,
// outcome codes, and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package krt_pkg;

  // Default table depth
  localparam int DEF_ENTRIES = 128;

  // Field widths
  localparam int KEY_HALF_W = 32;
  localparam int KEY_W      = 2 * KEY_HALF_W;
  localparam int PRES_W     = 16;
  localparam int VOLT_W     = 8;
  localparam int TEMP_W     = 8;
  localparam int VAL_W      = PRES_W + VOLT_W + TEMP_W;
  localparam int OUTCOME_W  = 2;

  // Operation codes
  localparam logic OP_SAVE = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Outcome codes
  localparam logic [OUTCOME_W-1:0] OUTCOME_MATCH  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_INSERT = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_MISS   = 2'd2;

  // Kind of result the datapath should form
  typedef enum logic [2:0] {
    RESP_MATCH_SPARE,   // match on the lowest free entry, its values returned
    RESP_MATCH_MEM,     // match on a stored entry, values from the value memory
    RESP_MATCH_NODATA,  // save that matched, zero data
    RESP_INSERT,        // save that took a free entry
    RESP_MISS           // load miss or save with table full
  } resp_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic       capture;    // latch the incoming transaction
    logic       spare_wr;   // update values of the lowest free entry
    logic       scan_init;  // rewind the scan pointer
    logic       scan_en;    // issue the next key read
    logic       val_wr;     // write values at the entry that just matched
    logic       insert;     // write keys and values at the first free entry
    logic       resp;       // emit a result
    resp_kind_t resp_kind;
  } krt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_load;
    logic zero_key;
    logic full;
    logic empty;
    logic scan_hit;
    logic scan_done;
  } krt_status_t;

endpackage

// File: rtl/krt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ctrl
// Controller for the keyed record table: sequences the key scan and decides
// between match, insert and miss for each transaction.
// ----------------------------------------------------------------------------
module krt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  krt_pkg::krt_status_t status,
  output krt_pkg::krt_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_VOUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.resp_kind = krt_pkg::RESP_MISS;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.zero_key) begin
          // The all-zero key names the lowest free entry
          state_next = ST_IDLE;
          cmd.resp   = 1'b1;
          if (status.full) begin
            cmd.resp_kind = krt_pkg::RESP_MISS;
          end else if (status.is_load) begin
            cmd.resp_kind = krt_pkg::RESP_MATCH_SPARE;
          end else begin
            cmd.spare_wr  = 1'b1;
            cmd.resp_kind = krt_pkg::RESP_MATCH_NODATA;
          end
        end else if (status.empty) begin
          state_next = ST_IDLE;
          cmd.resp   = 1'b1;
          if (status.is_load || status.full) begin
            cmd.resp_kind = krt_pkg::RESP_MISS;
          end else begin
            cmd.insert    = 1'b1;
            cmd.resp_kind = krt_pkg::RESP_INSERT;
          end
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_hit) begin
          if (status.is_load) begin
            state_next = ST_VOUT;
          end else begin
            cmd.val_wr    = 1'b1;
            cmd.resp      = 1'b1;
            cmd.resp_kind = krt_pkg::RESP_MATCH_NODATA;
            state_next    = ST_IDLE;
          end
        end else if (status.scan_done) begin
          state_next = ST_IDLE;
          cmd.resp   = 1'b1;
          if (status.is_load || status.full) begin
            cmd.resp_kind = krt_pkg::RESP_MISS;
          end else begin
            cmd.insert    = 1'b1;
            cmd.resp_kind = krt_pkg::RESP_INSERT;
          end
        end
      end
      ST_VOUT: begin
        // Value memory read data is ready now
        cmd.resp      = 1'b1;
        cmd.resp_kind = krt_pkg::RESP_MATCH_MEM;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/krt_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_dpath
// Datapath for the keyed record table: key and value memories, fill count,
// scan pointer with key compare, and the result registers.
// ----------------------------------------------------------------------------
module krt_dpath #(
  parameter int ENTRIES = krt_pkg::DEF_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  krt_pkg::krt_cmd_t                cmd,
  output krt_pkg::krt_status_t             status,
  input  logic                             operation,
  input  logic [krt_pkg::KEY_HALF_W-1:0]   group_key,
  input  logic [krt_pkg::KEY_HALF_W-1:0]   item_key,
  input  logic [krt_pkg::PRES_W-1:0]       wr_pressure,
  input  logic [krt_pkg::VOLT_W-1:0]       wr_voltage,
  input  logic [krt_pkg::TEMP_W-1:0]       wr_temperature,
  output logic                             done,
  output logic [krt_pkg::OUTCOME_W-1:0]    outcome,
  output logic [krt_pkg::PRES_W-1:0]       rd_pressure,
  output logic [krt_pkg::VOLT_W-1:0]       rd_voltage,
  output logic [krt_pkg::TEMP_W-1:0]       rd_temperature
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);

  localparam int VOLT_LO = krt_pkg::PRES_W;
  localparam int TEMP_LO = krt_pkg::PRES_W + krt_pkg::VOLT_W;

  // Memories. Occupied entries always form a prefix [0, fill), so entries at
  // or above fill read as free without any clearing.
  logic [krt_pkg::KEY_W-1:0] key_mem [ENTRIES];
  logic [krt_pkg::VAL_W-1:0] val_mem [ENTRIES];

  // Captured transaction
  logic                      op;
  logic [krt_pkg::KEY_W-1:0] key;
  logic [krt_pkg::VAL_W-1:0] vals;

  // Table bookkeeping
  logic [FILL_W-1:0]         fill;
  logic [krt_pkg::VAL_W-1:0] spare;   // values of the lowest free entry

  // Scan
  logic [FILL_W-1:0]         ptr;
  logic [FILL_W-1:0]         rd_ptr;
  logic                      rd_vld;
  logic                      issue;
  logic [krt_pkg::KEY_W-1:0] key_q;
  logic [krt_pkg::VAL_W-1:0] val_q;

  logic [IDX_W-1:0]          wr_idx;
  logic [krt_pkg::VAL_W-1:0] res_val;

  // Capture the transaction fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= operation;
      key  <= {group_key, item_key};
      vals <= {wr_temperature, wr_voltage, wr_pressure};
    end
  end

  // Status to the controller
  assign issue            = cmd.scan_en && (ptr < fill);
  assign status.is_load   = (op == krt_pkg::OP_LOAD);
  assign status.zero_key  = (key == '0);
  assign status.full      = (fill == FILL_W'(ENTRIES));
  assign status.empty     = (fill == '0);
  assign status.scan_hit  = rd_vld && (key_q == key);
  assign status.scan_done = !rd_vld && (ptr >= fill);

  // Advance the scan pointer and track read-data validity
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.scan_init) begin
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.scan_en) begin
      rd_vld <= issue;
      if (issue) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ptr <= ptr;
    end
  end

  // Registered reads: keys at the scan pointer, values at the compared entry
  always_ff @(posedge clk) begin
    key_q <= key_mem[ptr[IDX_W-1:0]];
    val_q <= val_mem[rd_ptr[IDX_W-1:0]];
  end

  // Write port: insert goes to the first free entry, update to the hit entry
  assign wr_idx = cmd.insert ? fill[IDX_W-1:0] : rd_ptr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.insert || cmd.val_wr) begin
      val_mem[wr_idx] <= vals;
    end
    if (cmd.insert) begin
      key_mem[wr_idx] <= key;
    end
  end

  // Fill count and the values held by the lowest free entry
  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      spare <= '0;
    end else if (cmd.insert) begin
      fill  <= fill + 1'b1;
      spare <= '0;
    end else if (cmd.spare_wr) begin
      spare <= vals;
    end
  end

  // Select result data
  always_comb begin
    case (cmd.resp_kind)
      krt_pkg::RESP_MATCH_SPARE: res_val = spare;
      krt_pkg::RESP_MATCH_MEM:   res_val = val_q;
      default:                   res_val = '0;
    endcase
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.resp;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      case (cmd.resp_kind)
        krt_pkg::RESP_MATCH_SPARE,
        krt_pkg::RESP_MATCH_MEM,
        krt_pkg::RESP_MATCH_NODATA: outcome <= krt_pkg::OUTCOME_MATCH;
        krt_pkg::RESP_INSERT:       outcome <= krt_pkg::OUTCOME_INSERT;
        default:                    outcome <= krt_pkg::OUTCOME_MISS;
      endcase
      rd_pressure    <= res_val[krt_pkg::PRES_W-1:0];
      rd_voltage     <= res_val[VOLT_LO +: krt_pkg::VOLT_W];
      rd_temperature <= res_val[TEMP_LO +: krt_pkg::TEMP_W];
    end
  end

endmodule

// File: rtl/keyed_record_table_core.sv
`timescale 1ns / 1ps
// Timing: done follows start soonest for the all-zero key or an empty table;
// otherwise the wait grows with fill (occupied entries), set by the key scan
// reading one entry per cycle from the key memory.
// Throughput: one transaction at a time; start is taken whenever busy is low.
// Reset: synchronous rst empties the table (fill count and spare values
// cleared, no clearing pass) and drops any transaction in flight.
// ----------------------------------------------------------------------------
// keyed_record_table_core
// Fully associative table of records keyed by a pair of 32-bit ids, with
// save (update or insert) and load (lookup) transactions.
// ----------------------------------------------------------------------------
module keyed_record_table_core #(
  parameter int ENTRIES = krt_pkg::DEF_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             operation,
  input  logic [krt_pkg::KEY_HALF_W-1:0]   group_key,
  input  logic [krt_pkg::KEY_HALF_W-1:0]   item_key,
  input  logic [krt_pkg::PRES_W-1:0]       wr_pressure,
  input  logic [krt_pkg::VOLT_W-1:0]       wr_voltage,
  input  logic [krt_pkg::TEMP_W-1:0]       wr_temperature,
  output logic                             done,
  output logic [krt_pkg::OUTCOME_W-1:0]    outcome,
  output logic [krt_pkg::PRES_W-1:0]       rd_pressure,
  output logic [krt_pkg::VOLT_W-1:0]       rd_voltage,
  output logic [krt_pkg::TEMP_W-1:0]       rd_temperature
);

  krt_pkg::krt_cmd_t    cmd;
  krt_pkg::krt_status_t status;

  // Sequence each transaction
  krt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Storage, compare and result registers
  krt_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .group_key      (group_key),
    .item_key       (item_key),
    .wr_pressure    (wr_pressure),
    .wr_voltage     (wr_voltage),
    .wr_temperature (wr_temperature),
    .done           (done),
    .outcome        (outcome),
    .rd_pressure    (rd_pressure),
    .rd_voltage     (rd_voltage),
    .rd_temperature (rd_temperature)
  );

endmodule
